// ----- hw/rtl/nps_pkg.sv -----
// shared types and constants of the non-preemptive priority scheduler
package nps_pkg;

  localparam int ARR_W  = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 21;
  localparam int ID_W   = 5;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival_time;
    logic [BURST_W-1:0] burst_time;
    logic [PRIO_W-1:0]  priority_req;
    logic               last_job;
  } job_req_t;

  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic              last_result;
  } job_res_t;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } job_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic issue;
    logic decide;
    logic jump;
    logic commit;
  } nps_cmd_t;

  typedef struct packed {
    logic last_issue;
    logic pick_valid;
    logic out_free;
    logic final_job;
  } nps_sts_t;

endpackage

// ----- hw/rtl/nps_ctrl.sv -----
// scheduler controller state machine
module nps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  logic                job_last,
  output logic                job_stall,
  input  nps_pkg::nps_sts_t   sts,
  output nps_pkg::nps_cmd_t   cmd
);

  nps_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nps_pkg::ST_IDLE: begin
        if (job_valid && job_last) begin
          state_next = nps_pkg::ST_SCAN;
        end
      end
      nps_pkg::ST_SCAN: begin
        if (sts.last_issue) begin
          state_next = nps_pkg::ST_DRAIN;
        end
      end
      nps_pkg::ST_DRAIN: begin
        state_next = nps_pkg::ST_DECIDE;
      end
      nps_pkg::ST_DECIDE: begin
        if (sts.pick_valid) begin
          state_next = nps_pkg::ST_RESULT;
        end else begin
          state_next = nps_pkg::ST_SCAN;
        end
      end
      nps_pkg::ST_RESULT: begin
        if (sts.out_free) begin
          state_next = sts.final_job ? nps_pkg::ST_IDLE : nps_pkg::ST_SCAN;
        end
      end
      default: state_next = nps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    job_stall = 1'b1;
    unique case (state)
      nps_pkg::ST_IDLE: begin
        job_stall      = 1'b0;
        cmd.load       = job_valid;
        cmd.scan_start = job_valid && job_last;
      end
      nps_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      nps_pkg::ST_DRAIN: begin
      end
      nps_pkg::ST_DECIDE: begin
        cmd.decide     = sts.pick_valid;
        cmd.jump       = !sts.pick_valid;
        cmd.scan_start = !sts.pick_valid;
      end
      nps_pkg::ST_RESULT: begin
        cmd.commit     = sts.out_free;
        cmd.scan_start = sts.out_free && !sts.final_job;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/nps_datapath.sv -----
// job store, selection scan, time keeping and result register
module nps_datapath #(
  parameter int MAX_JOBS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  nps_pkg::job_req_t   job,
  input  nps_pkg::nps_cmd_t   cmd,
  output nps_pkg::nps_sts_t   sts,
  output logic                result_valid,
  input  logic                result_stall,
  output nps_pkg::job_res_t   result
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  nps_pkg::job_entry_t store [MAX_JOBS];
  nps_pkg::job_entry_t rd_data;

  logic [MAX_JOBS-1:0]          done_flags;
  logic [CNT_W-1:0]             job_count;
  logic [CNT_W-1:0]             done_cnt;
  logic [nps_pkg::TIME_W-1:0]   cur_time;
  logic [IDX_W-1:0]             addr;
  logic [IDX_W-1:0]             rd_idx;
  logic                         rd_vld;

  logic                         pick_vld;
  logic [IDX_W-1:0]             pick_idx;
  logic [nps_pkg::PRIO_W-1:0]   pick_prio;
  logic [nps_pkg::ARR_W-1:0]    pick_arr;
  logic [nps_pkg::BURST_W-1:0]  pick_burst;
  logic                         min_vld;
  logic [nps_pkg::ARR_W-1:0]    min_arr;

  logic [nps_pkg::TIME_W-1:0]   ct;
  logic [nps_pkg::TIME_W-1:0]   wt;
  logic [IDX_W:0]               id_ext;
  logic                         cand_open;
  logic                         cand_ready;
  logic                         cand_better;

  // job store
  always_ff @(posedge clk) begin
    if (cmd.load && (job_count < CNT_W'(MAX_JOBS))) begin
      store[job_count[IDX_W-1:0]] <= '{arrival: job.arrival_time,
                                       burst:   job.burst_time,
                                       prio:    job.priority_req};
    end
    if (cmd.issue) begin
      rd_data <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= addr;
    if (cmd.scan_start) begin
      addr <= '0;
    end else if (cmd.issue) begin
      addr <= addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
    end
  end

  assign cand_open   = rd_vld && !done_flags[rd_idx];
  assign cand_ready  = {{(nps_pkg::TIME_W - nps_pkg::ARR_W){1'b0}}, rd_data.arrival} <= cur_time;
  assign cand_better = !pick_vld || (rd_data.prio < pick_prio) ||
                       ((rd_data.prio == pick_prio) && (rd_data.arrival < pick_arr));

  // candidate tracking over one pass
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      pick_vld <= 1'b0;
      min_vld  <= 1'b0;
    end else if (cand_open) begin
      if (!min_vld || (rd_data.arrival < min_arr)) begin
        min_vld <= 1'b1;
        min_arr <= rd_data.arrival;
      end
      if (cand_ready && cand_better) begin
        pick_vld   <= 1'b1;
        pick_idx   <= rd_idx;
        pick_prio  <= rd_data.prio;
        pick_arr   <= rd_data.arrival;
        pick_burst <= rd_data.burst;
      end
    end
  end

  // completion and waiting time of the chosen job
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      ct <= cur_time + {{(nps_pkg::TIME_W - nps_pkg::BURST_W){1'b0}}, pick_burst};
      wt <= cur_time - {{(nps_pkg::TIME_W - nps_pkg::ARR_W){1'b0}}, pick_arr};
    end
  end

  assign id_ext = {1'b0, pick_idx} + 1'b1;

  // set state
  always_ff @(posedge clk) begin
    if (rst) begin
      job_count  <= '0;
      done_cnt   <= '0;
      cur_time   <= '0;
      done_flags <= '0;
    end else begin
      if (cmd.load && (job_count < CNT_W'(MAX_JOBS))) begin
        job_count <= job_count + 1'b1;
      end
      if (cmd.jump) begin
        cur_time <= {{(nps_pkg::TIME_W - nps_pkg::ARR_W){1'b0}}, min_arr};
      end
      if (cmd.commit) begin
        if (sts.final_job) begin
          job_count  <= '0;
          done_cnt   <= '0;
          cur_time   <= '0;
          done_flags <= '0;
        end else begin
          done_cnt             <= done_cnt + 1'b1;
          cur_time             <= ct;
          done_flags[pick_idx] <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.job_id          <= nps_pkg::ID_W'(id_ext);
      result.completion_time <= ct;
      result.turnaround_time <= ct - {{(nps_pkg::TIME_W - nps_pkg::ARR_W){1'b0}}, pick_arr};
      result.waiting_time    <= wt;
      result.last_result     <= sts.final_job;
    end
  end

  assign sts.last_issue = cmd.issue && (CNT_W'(addr) == job_count - CNT_W'(1));
  assign sts.pick_valid = pick_vld;
  assign sts.out_free   = !result_valid || !result_stall;
  assign sts.final_job  = (done_cnt + 1'b1) == job_count;

  a_commit_has_pick: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> pick_vld)
    else $error("result committed without a chosen job");

  a_jump_has_min: assert property (@(posedge clk) disable iff (rst)
    cmd.jump |-> min_vld)
    else $error("time jump without an unfinished job");

  a_commit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (done_cnt < job_count))
    else $error("more results than stored jobs");

  a_final_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && sts.final_job |=> (job_count == '0) && (done_flags == '0))
    else $error("job set not cleared after final result");

endmodule

// ----- hw/rtl/nonpreemptive_priority_scheduler.sv -----
// top level of the non-preemptive priority scheduler
// Jobs enter on the job channel (job_valid / job_stall / job), one request
// per cycle while the block is loading, numbered from 1 in load order. Up to
// MAX_JOBS jobs are kept; further jobs are dropped. A request with last_job
// set starts the schedule, and job_stall stays high until the schedule is
// done. Results leave on the result channel (result_valid / result_stall /
// result), one request per job in run order, last_result set on the final one.
// Each decision scans the stored jobs through the job memory, one entry a
// cycle; when no job is ready, time jumps to the next arrival and the scan
// repeats. A result waits in the output register while result_stall is high,
// and the next decision holds until that register is free. Reset clears the
// job count, the finished flags, the time and the output valid; the job
// memory needs no clearing.
module nonpreemptive_priority_scheduler #(
  parameter int MAX_JOBS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_stall,
  input  nps_pkg::job_req_t  job,
  output logic               result_valid,
  input  logic               result_stall,
  output nps_pkg::job_res_t  result
);

  nps_pkg::nps_cmd_t cmd;
  nps_pkg::nps_sts_t sts;

  nps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_last  (job.last_job),
    .job_stall (job_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  nps_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// testbench of the non-preemptive priority scheduler: directed table, random job sets, predictor
module tb_top;

  localparam int JOB_CAP = 16;
  localparam int RAND_ITEMS = 435;
  localparam int DRAIN_LIMIT = 20000;

  typedef nps_pkg::job_res_t res_q_t[$];

  typedef struct {
    nps_pkg::job_req_t req;
    bit                typed;
    nps_pkg::job_res_t res;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              job_valid;
  logic              job_stall;
  nps_pkg::job_req_t job;
  logic              result_valid;
  logic              result_stall;
  nps_pkg::job_res_t result;

  nps_pkg::job_entry_t held_jobs[$];
  nps_pkg::job_res_t   due_results[$];
  dir_row_t            dir_tab[$];
  nps_pkg::job_res_t   head_res;
  int                  err_cnt = 0;
  bit                  calm = 1'b0;

  nonpreemptive_priority_scheduler #(
    .MAX_JOBS(JOB_CAP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .job_valid(job_valid),
    .job_stall(job_stall),
    .job(job),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic nps_pkg::job_req_t mk_job(int arr, int burst, int prio, int last);
    nps_pkg::job_req_t r;
    r.arrival_time = arr[nps_pkg::ARR_W-1:0];
    r.burst_time   = burst[nps_pkg::BURST_W-1:0];
    r.priority_req = prio[nps_pkg::PRIO_W-1:0];
    r.last_job     = last[0];
    return r;
  endfunction

  function automatic nps_pkg::job_res_t mk_res(int id, int ct, int tat, int wt, int last);
    nps_pkg::job_res_t r;
    r.job_id          = id[nps_pkg::ID_W-1:0];
    r.completion_time = ct[nps_pkg::TIME_W-1:0];
    r.turnaround_time = tat[nps_pkg::TIME_W-1:0];
    r.waiting_time    = wt[nps_pkg::TIME_W-1:0];
    r.last_result     = last[0];
    return r;
  endfunction

  // lower priority number, then earlier arrival, then lower id
  function automatic bit runs_first(int a, int b);
    if (held_jobs[a].prio != held_jobs[b].prio) return held_jobs[a].prio < held_jobs[b].prio;
    if (held_jobs[a].arrival != held_jobs[b].arrival)
      return held_jobs[a].arrival < held_jobs[b].arrival;
    return a < b;
  endfunction

  function automatic res_q_t plan_schedule();
    res_q_t                     plan;
    bit                         fin[JOB_CAP];
    logic [nps_pkg::TIME_W-1:0] now;
    logic [nps_pkg::TIME_W-1:0] ct;
    logic [nps_pkg::TIME_W-1:0] tat;
    logic [nps_pkg::TIME_W-1:0] wt;
    logic [nps_pkg::TIME_W-1:0] earliest;
    int                         pick;
    int                         done;
    int                         n;
    bit                         found;
    n = held_jobs.size();
    now = '0;
    done = 0;
    plan = {};
    foreach (fin[i]) fin[i] = 1'b0;
    while (done < n) begin
      pick = -1;
      for (int i = 0; i < n; i++) begin
        if (!fin[i] && nps_pkg::TIME_W'(held_jobs[i].arrival) <= now) begin
          if (pick < 0 || runs_first(i, pick)) pick = i;
        end
      end
      if (pick < 0) begin
        // nothing ready: jump to the next arrival
        found = 1'b0;
        earliest = '0;
        for (int i = 0; i < n; i++) begin
          if (!fin[i] && (!found || nps_pkg::TIME_W'(held_jobs[i].arrival) < earliest)) begin
            earliest = nps_pkg::TIME_W'(held_jobs[i].arrival);
            found = 1'b1;
          end
        end
        now = earliest;
      end else begin
        ct  = now + nps_pkg::TIME_W'(held_jobs[pick].burst);
        tat = ct - nps_pkg::TIME_W'(held_jobs[pick].arrival);
        wt  = tat - nps_pkg::TIME_W'(held_jobs[pick].burst);
        now = ct;
        fin[pick] = 1'b1;
        done++;
        plan.push_back(mk_res(pick + 1, int'(ct), int'(tat), int'(wt), int'(done == n)));
      end
    end
    held_jobs = {};
    return plan;
  endfunction

  function automatic res_q_t take_job(nps_pkg::job_req_t r);
    nps_pkg::job_entry_t e;
    res_q_t              plan;
    plan = {};
    // store full: the job is dropped
    if (held_jobs.size() < JOB_CAP) begin
      e.arrival = r.arrival_time;
      e.burst   = r.burst_time;
      e.prio    = r.priority_req;
      held_jobs.push_back(e);
    end
    if (r.last_job) plan = plan_schedule();
    return plan;
  endfunction

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  task automatic add_row(nps_pkg::job_req_t r, bit typed = 1'b0,
                         nps_pkg::job_res_t want = '0);
    dir_row_t row;
    row.req = r;
    row.typed = typed;
    row.res = want;
    dir_tab.push_back(row);
  endtask

  task automatic build_table();
    // single jobs at the extremes
    add_row(mk_job(0, 5, 0, 1), 1'b1, mk_res(1, 5, 5, 0, 1));
    add_row(mk_job(65535, 65535, 255, 1), 1'b1, mk_res(1, 131070, 65535, 0, 1));
    add_row(mk_job(0, 0, 0, 1), 1'b1, mk_res(1, 0, 0, 0, 1));
    // ties on priority, broken by arrival and by id
    add_row(mk_job(5, 4, 1, 0));
    add_row(mk_job(5, 4, 1, 0));
    add_row(mk_job(0, 10, 3, 0));
    add_row(mk_job(3, 2, 1, 1));
    // idle gap before the first arrival
    add_row(mk_job(100, 5, 0, 0));
    add_row(mk_job(50, 5, 9, 1));
    // full store, the closing request is dropped but starts the schedule
    for (int k = 0; k < JOB_CAP; k++) add_row(mk_job((k * 37) % 200, 1 + k * 3, (k * 5) % 4, 0));
    add_row(mk_job(65535, 65535, 255, 1));
  endtask

  task automatic send_job(nps_pkg::job_req_t r, bit typed, nps_pkg::job_res_t want);
    res_q_t plan;
    if (!calm) begin
      while ($urandom_range(0, 99) < 33) begin
        job_valid <= 1'b0;
        @(negedge clk);
      end
    end
    job_valid <= 1'b1;
    job <= r;
    @(posedge clk);
    while (job_stall) @(posedge clk);
    plan = take_job(r);
    if (typed) due_results.push_back(want);
    else foreach (plan[i]) due_results.push_back(plan[i]);
    @(negedge clk);
  endtask

  task automatic send_random_set(inout int sent);
    nps_pkg::job_req_t r;
    int                n;
    int                amode;
    int                pick;
    bit                short_burst;
    bit                few_prio;
    pick = $urandom_range(0, 99);
    if (pick < 10) n = $urandom_range(JOB_CAP + 1, JOB_CAP + 4);
    else if (pick < 25) n = JOB_CAP;
    else n = $urandom_range(1, JOB_CAP);
    amode = $urandom_range(0, 2);
    short_burst = 1'($urandom_range(0, 1));
    few_prio = 1'($urandom_range(0, 1));
    for (int k = 0; k < n; k++) begin
      case (amode)
        0: r.arrival_time = nps_pkg::ARR_W'($urandom_range(0, 63));
        1: r.arrival_time = nps_pkg::ARR_W'($urandom_range(0, 4095));
        default: r.arrival_time = nps_pkg::ARR_W'($urandom_range(0, 65535));
      endcase
      r.burst_time = short_burst ? nps_pkg::BURST_W'($urandom_range(0, 15))
                                 : nps_pkg::BURST_W'($urandom_range(0, 65535));
      r.priority_req = few_prio ? nps_pkg::PRIO_W'($urandom_range(0, 3))
                                : nps_pkg::PRIO_W'($urandom_range(0, 255));
      r.last_job = (k == n - 1);
      calm = (sent >= 200 && sent < 300);
      send_job(r, 1'b0, '0);
      sent++;
    end
  endtask

  always @(negedge clk) result_stall <= !calm && ($urandom_range(0, 99) < 33);

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        report($sformatf("result for job %0d with nothing expected", result.job_id));
      end else begin
        head_res = due_results.pop_front();
        if (result.job_id !== head_res.job_id)
          report($sformatf("job_id %0d, want %0d", result.job_id, head_res.job_id));
        if (result.completion_time !== head_res.completion_time)
          report($sformatf("job %0d completion_time %0d, want %0d", head_res.job_id,
                           result.completion_time, head_res.completion_time));
        if (result.turnaround_time !== head_res.turnaround_time)
          report($sformatf("job %0d turnaround_time %0d, want %0d", head_res.job_id,
                           result.turnaround_time, head_res.turnaround_time));
        if (result.waiting_time !== head_res.waiting_time)
          report($sformatf("job %0d waiting_time %0d, want %0d", head_res.job_id,
                           result.waiting_time, head_res.waiting_time));
        if (result.last_result !== head_res.last_result)
          report($sformatf("job %0d last_result %0d, want %0d", head_res.job_id,
                           result.last_result, head_res.last_result));
      end
    end
  end

  initial begin
    int sent;
    int waited;
    bit paused;
    rst = 1'b1;
    job_valid = 1'b0;
    job = '0;
    sent = 0;
    waited = 0;
    paused = 1'b0;
    build_table();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i]) send_job(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
    job_valid <= 1'b0;
    do @(negedge clk); while (due_results.size() != 0);
    while (sent < RAND_ITEMS) begin
      send_random_set(sent);
      // hold off until the whole schedule has drained
      if (!paused && sent >= 150) begin
        job_valid <= 1'b0;
        do @(negedge clk); while (due_results.size() != 0);
        paused = 1'b1;
      end
    end
    job_valid <= 1'b0;
    calm = 1'b0;
    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (due_results.size() != 0) report($sformatf("%0d results never came", due_results.size()));
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
